// ----- hdl/rae_pkg.sv -----
package rae_pkg;

  localparam int REGISTER_COUNT_DEF = 32;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 5;
  localparam int OP_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_AND   = 4'd2,
    OP_XOR   = 4'd3,
    OP_OR    = 4'd4,
    OP_ADDI  = 4'd5,
    OP_SUBI  = 4'd6,
    OP_ANDI  = 4'd7,
    OP_XORI  = 4'd8,
    OP_ORI   = 4'd9,
    OP_MOVR  = 4'd10,
    OP_MOVI  = 4'd11,
    OP_SWAP  = 4'd12,
    OP_LOAD0 = 4'd13,
    OP_READ0 = 4'd14
  } op_t;

  // Two write ports; port b wins when both hit the same register.
  typedef struct packed {
    logic                 we_a;
    logic [REG_IDX_W-1:0] idx_a;
    logic [DATA_W-1:0]    data_a;
    logic                 we_b;
    logic [REG_IDX_W-1:0] idx_b;
    logic [DATA_W-1:0]    data_b;
  } rf_wr_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              parity;
    logic              zero;
    logic              sign;
    logic              overflow;
  } result_t;

endpackage

// ----- hdl/rae_in_if.sv -----
interface rae_in_if;
  import rae_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             operation;
  logic [REG_IDX_W-1:0]        dest_reg;
  logic [REG_IDX_W-1:0]        src_a_reg;
  logic [REG_IDX_W-1:0]        src_b_reg;
  logic signed [DATA_W-1:0]    immediate;

  modport source (
    output valid, operation, dest_reg, src_a_reg, src_b_reg, immediate,
    input  ready
  );

  modport sink (
    input  valid, operation, dest_reg, src_a_reg, src_b_reg, immediate,
    output ready
  );

endinterface

// ----- hdl/rae_out_if.sv -----
interface rae_out_if;
  import rae_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     parity_flag;
  logic                     zero_flag;
  logic                     sign_flag;
  logic                     overflow_flag;

  modport source (
    output valid, result_value, parity_flag, zero_flag, sign_flag, overflow_flag,
    input  ready
  );

  modport sink (
    input  valid, result_value, parity_flag, zero_flag, sign_flag, overflow_flag,
    output ready
  );

endinterface

// ----- hdl/rae_regfile.sv -----
module rae_regfile #(
  parameter int REGISTER_COUNT = rae_pkg::REGISTER_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rae_pkg::REG_IDX_W-1:0]       rd_a_idx,
  input  logic [rae_pkg::REG_IDX_W-1:0]       rd_b_idx,
  input  logic [rae_pkg::REG_IDX_W-1:0]       rd_c_idx,
  output logic [rae_pkg::DATA_W-1:0]          rd_a_data,
  output logic [rae_pkg::DATA_W-1:0]          rd_b_data,
  output logic [rae_pkg::DATA_W-1:0]          rd_c_data,
  input  rae_pkg::rf_wr_t                     wr
);
  import rae_pkg::*;

  localparam int ADDR_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [DATA_W-1:0] regs_r   [REGISTER_COUNT];
  logic [DATA_W-1:0] regs_nxt [REGISTER_COUNT];

  // Indexes past the end of the file read as zero.
  function automatic logic [DATA_W-1:0] read_at(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    if (ext < 32'(REGISTER_COUNT)) begin
      return regs_r[ext[ADDR_W-1:0]];
    end
    return '0;
  endfunction

  // The read ports must follow the file contents as well as the indexes.
  always_comb begin
    rd_a_data = read_at(rd_a_idx);
    rd_b_data = read_at(rd_b_idx);
    rd_c_data = read_at(rd_c_idx);
  end

  // Writes past the end of the file match no entry and are dropped.
  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      regs_nxt[i] = regs_r[i];
      if (wr.we_a && (32'(wr.idx_a) == 32'(i))) begin
        regs_nxt[i] = wr.data_a;
      end
      if (wr.we_b && (32'(wr.idx_b) == 32'(i))) begin
        regs_nxt[i] = wr.data_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
    end
  end

endmodule

// ----- hdl/rae_alu.sv -----
module rae_alu (
  input  logic [rae_pkg::OP_W-1:0]      op,
  input  logic [rae_pkg::REG_IDX_W-1:0] dest,
  input  logic [rae_pkg::REG_IDX_W-1:0] src_a,
  input  logic [rae_pkg::DATA_W-1:0]    a_val,
  input  logic [rae_pkg::DATA_W-1:0]    b_val,
  input  logic [rae_pkg::DATA_W-1:0]    d_val,
  input  logic [rae_pkg::DATA_W-1:0]    imm,
  output rae_pkg::result_t              res,
  output rae_pkg::rf_wr_t               wr
);
  import rae_pkg::*;

  logic [DATA_W-1:0] b_opnd;
  logic [DATA_W-1:0] r;
  logic              alu_op;
  logic              a_pos, a_neg, b_pos, b_neg, r_pos, r_neg;

  always_comb begin
    b_opnd = ((op >= OP_ADDI) && (op <= OP_ORI)) ? imm : b_val;
    r      = d_val;
    alu_op = 1'b0;
    wr     = '0;
    wr.idx_a = dest;
    wr.idx_b = src_a;
    wr.data_b = d_val;
    unique case (op)
      OP_ADD, OP_ADDI: begin
        r = a_val + b_opnd;
        alu_op = 1'b1;
        wr.we_a = 1'b1;
      end
      OP_SUB, OP_SUBI: begin
        r = a_val - b_opnd;
        alu_op = 1'b1;
        wr.we_a = 1'b1;
      end
      OP_AND, OP_ANDI: begin
        r = a_val & b_opnd;
        alu_op = 1'b1;
        wr.we_a = 1'b1;
      end
      OP_XOR, OP_XORI: begin
        r = a_val ^ b_opnd;
        alu_op = 1'b1;
        wr.we_a = 1'b1;
      end
      OP_OR, OP_ORI: begin
        r = a_val | b_opnd;
        alu_op = 1'b1;
        wr.we_a = 1'b1;
      end
      OP_MOVR: begin
        r = a_val;
        wr.we_a = 1'b1;
      end
      OP_MOVI: begin
        r = imm;
        wr.we_a = 1'b1;
      end
      OP_SWAP: begin
        // The old destination value lands in the source register.
        r = a_val;
        wr.we_a = 1'b1;
        wr.we_b = 1'b1;
      end
      OP_LOAD0: begin
        r = imm;
        wr.we_a = 1'b1;
        wr.idx_a = '0;
      end
      OP_READ0: begin
        r = d_val;
      end
      default: begin
        r = d_val;
      end
    endcase
    wr.data_a = r;
  end

  assign a_pos = (a_val != '0) && !a_val[DATA_W-1];
  assign a_neg = a_val[DATA_W-1];
  assign b_pos = (b_opnd != '0) && !b_opnd[DATA_W-1];
  assign b_neg = b_opnd[DATA_W-1];
  assign r_pos = (r != '0) && !r[DATA_W-1];
  assign r_neg = r[DATA_W-1];

  assign res.value    = r;
  assign res.parity   = ^r;
  assign res.zero     = (r == '0);
  assign res.sign     = r[DATA_W-1];
  assign res.overflow = alu_op && ((a_pos && b_pos && r_neg) || (a_neg && b_neg && r_pos));

endmodule

// ----- hdl/register_alu_execute_with_flags_core.sv -----
// An accepted beat waits in the execute stage until the output register can take it.
// Throughput: one instruction per cycle unless out_ stalls; the register file is read and
// written in the same cycle, so a dependent instruction may follow directly with no stall.
// Reset: synchronous, active low; clears all registers of the file and both valid bits.
// After reset the block accepts a beat in the very next cycle.
module register_alu_execute_with_flags_core #(
  parameter int REGISTER_COUNT = rae_pkg::REGISTER_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rae_in_if.sink    in_chan,
  rae_out_if.source out_chan
);
  import rae_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [OP_W-1:0]       op_r;
  logic [REG_IDX_W-1:0]  dest_r, src_a_r, src_b_r;
  logic [DATA_W-1:0]     imm_r;

  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r;

  logic                  in_fire, s1_adv;
  logic [REG_IDX_W-1:0]  rd_c_idx;
  logic [DATA_W-1:0]     a_val, b_val, d_val;
  result_t               alu_res;
  rf_wr_t                alu_wr, wr_gated;

  // The execute stage moves on whenever the output register is free or being drained.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_chan.operation;
      dest_r  <= in_chan.dest_reg;
      src_a_r <= in_chan.src_a_reg;
      src_b_r <= in_chan.src_b_reg;
      imm_r   <= in_chan.immediate;
    end
    if (s1_adv) begin
      out_res_r <= alu_res;
    end
  end

  // The third read port serves the old destination, or register 0 for a read-out.
  assign rd_c_idx = (op_r == OP_READ0) ? '0 : dest_r;

  rae_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_a_idx  (src_a_r),
    .rd_b_idx  (src_b_r),
    .rd_c_idx  (rd_c_idx),
    .rd_a_data (a_val),
    .rd_b_data (b_val),
    .rd_c_data (d_val),
    .wr        (wr_gated)
  );

  rae_alu u_alu (
    .op    (op_r),
    .dest  (dest_r),
    .src_a (src_a_r),
    .a_val (a_val),
    .b_val (b_val),
    .d_val (d_val),
    .imm   (imm_r),
    .res   (alu_res),
    .wr    (alu_wr)
  );

  always_comb begin
    wr_gated      = alu_wr;
    wr_gated.we_a = alu_wr.we_a && s1_adv;
    wr_gated.we_b = alu_wr.we_b && s1_adv;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_value  = out_res_r.value;
  assign out_chan.parity_flag   = out_res_r.parity;
  assign out_chan.zero_flag     = out_res_r.zero;
  assign out_chan.sign_flag     = out_res_r.sign;
  assign out_chan.overflow_flag = out_res_r.overflow;

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |=>
      (s1_valid_r && $stable(op_r) && $stable(imm_r) && $stable(dest_r)))
    else $error("execute stage changed while the output was stalled");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced instruction did not reach the output register");

  a_ovf_alu_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (op_r >= OP_MOVR)) |=> !out_res_r.overflow)
    else $error("overflow flag set for a non-ALU operation");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (op_r == OP_READ0)) |-> (!wr_gated.we_a && !wr_gated.we_b))
    else $error("register read-out wrote the register file");
`endif

endmodule

// ----- verif/rae_exec_checker.sv -----
module rae_exec_checker #(
  parameter int REGISTER_COUNT = rae_pkg::REGISTER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rae_in_if    in_mon,
  rae_out_if   out_mon,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rae_pkg::*;

  logic [DATA_W-1:0] reg_file [32];
  result_t           expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  // Indexes past the end of the file read as zero and drop their writes.
  function automatic logic [DATA_W-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
    return (int'(idx) < REGISTER_COUNT) ? reg_file[idx] : '0;
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    if (int'(idx) < REGISTER_COUNT) reg_file[idx] = val;
  endtask

  function automatic logic is_pos(input logic [DATA_W-1:0] v);
    return (v != '0) && !v[DATA_W-1];
  endfunction

  task automatic execute_instr(input logic [OP_W-1:0] op,
                               input logic [REG_IDX_W-1:0] d, sa, sb,
                               input logic [DATA_W-1:0] imm,
                               output result_t res);
    logic [DATA_W-1:0] a, b, r, old_d;
    logic              ovf;
    a   = read_reg(sa);
    b   = (op >= OP_ADDI && op <= OP_ORI) ? imm : read_reg(sb);
    ovf = 1'b0;
    case (op)
      OP_ADD, OP_ADDI: r = a + b;
      OP_SUB, OP_SUBI: r = a - b;
      OP_AND, OP_ANDI: r = a & b;
      OP_XOR, OP_XORI: r = a ^ b;
      OP_OR, OP_ORI:   r = a | b;
      OP_MOVR: begin
        r = a;
        write_reg(d, r);
      end
      OP_MOVI: begin
        r = imm;
        write_reg(d, r);
      end
      OP_SWAP: begin
        // The second write lands last, so a swap with itself leaves the register alone.
        old_d = read_reg(d);
        r = a;
        write_reg(d, a);
        write_reg(sa, old_d);
      end
      OP_LOAD0: begin
        r = imm;
        write_reg('0, r);
      end
      OP_READ0: r = read_reg('0);
      default:  r = read_reg(d);
    endcase
    if (op <= OP_ORI) begin
      write_reg(d, r);
      // Same-sign rule on the operands as read, applied to every ALU form.
      ovf = (is_pos(a) && is_pos(b) && r[DATA_W-1]) ||
            (a[DATA_W-1] && b[DATA_W-1] && is_pos(r));
    end
    res.value    = r;
    res.parity   = ^r;
    res.zero     = (r == '0);
    res.sign     = r[DATA_W-1];
    res.overflow = ovf;
  endtask

  task automatic compare_result(input result_t want);
    if (out_mon.result_value !== want.value)
      report_mismatch($sformatf("result_value: got %h, expected %h",
                                out_mon.result_value, want.value));
    if (out_mon.parity_flag !== want.parity)
      report_mismatch($sformatf("parity_flag: got %b, expected %b (value %h)",
                                out_mon.parity_flag, want.parity, want.value));
    if (out_mon.zero_flag !== want.zero)
      report_mismatch($sformatf("zero_flag: got %b, expected %b (value %h)",
                                out_mon.zero_flag, want.zero, want.value));
    if (out_mon.sign_flag !== want.sign)
      report_mismatch($sformatf("sign_flag: got %b, expected %b (value %h)",
                                out_mon.sign_flag, want.sign, want.value));
    if (out_mon.overflow_flag !== want.overflow)
      report_mismatch($sformatf("overflow_flag: got %b, expected %b (value %h)",
                                out_mon.overflow_flag, want.overflow, want.value));
  endtask

  // A result beat always belongs to an earlier instruction, so it is checked
  // before the instruction accepted at the same edge is queued.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) reg_file[i] = '0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no instruction outstanding",
                                    out_mon.result_value));
        end else begin
          want = expected_q.pop_front();
          compare_result(want);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        execute_instr(in_mon.operation, in_mon.dest_reg, in_mon.src_a_reg,
                      in_mon.src_b_reg, in_mon.immediate, want);
        expected_q.push_back(want);
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ----- verif/register_alu_execute_with_flags_core_tb.sv -----
module register_alu_execute_with_flags_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rae_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 4'd15;
  localparam int ITEM_COUNT  = 1150;
  localparam int DRAIN_EVERY = 250;
  localparam int CYCLE_LIMIT = 400_000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   cycle_count;
  bit   send_burst;
  bit   take_burst;

  rae_in_if  in_chan ();
  rae_out_if out_chan ();

  register_alu_execute_with_flags_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rae_exec_checker exec_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("register_alu_execute_with_flags_core: mismatch");
      $finish;
    end
  end

  function automatic logic [REG_IDX_W-1:0] draw_idx();
    // A third of the indexes hit a few low registers so results feed later operands.
    return ($urandom_range(0, 2) == 0) ? REG_IDX_W'($urandom_range(0, 3))
                                       : REG_IDX_W'($urandom_range(0, 31));
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows the beat, with valid still high so a back-to-back beat needs no toggle.
  task automatic send_instr(input logic [OP_W-1:0] op,
                            input logic [REG_IDX_W-1:0] d, sa, sb,
                            input logic [DATA_W-1:0] imm);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.operation = op;
    in_chan.dest_reg  = d;
    in_chan.src_a_reg = sa;
    in_chan.src_b_reg = sb;
    in_chan.immediate = imm;
    in_chan.valid     = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] imm;
    in_chan.valid     = 1'b0;
    in_chan.operation = '0;
    in_chan.dest_reg  = '0;
    in_chan.src_a_reg = '0;
    in_chan.src_b_reg = '0;
    in_chan.immediate = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme values, every operation, positive and negative overflow,
    // swap of a register with itself and the unused operation code.
    send_instr(OP_READ0, 5'd0,  5'd0,  5'd0,  32'h0);
    send_instr(OP_LOAD0, 5'd0,  5'd0,  5'd0,  32'h7fff_ffff);
    send_instr(OP_MOVI,  5'd1,  5'd0,  5'd0,  32'h8000_0000);
    send_instr(OP_MOVI,  5'd31, 5'd0,  5'd0,  32'hffff_ffff);
    send_instr(OP_MOVR,  5'd2,  5'd0,  5'd31, 32'h0);
    send_instr(OP_ADD,   5'd3,  5'd0,  5'd2,  32'h0);
    send_instr(OP_ADD,   5'd4,  5'd1,  5'd31, 32'h0);
    send_instr(OP_SUB,   5'd5,  5'd31, 5'd1,  32'h0);
    send_instr(OP_AND,   5'd7,  5'd31, 5'd1,  32'h0);
    send_instr(OP_XOR,   5'd8,  5'd0,  5'd31, 32'h0);
    send_instr(OP_OR,    5'd9,  5'd1,  5'd0,  32'h0);
    send_instr(OP_ADDI,  5'd10, 5'd0,  5'd31, 32'h0000_0001);
    send_instr(OP_SUBI,  5'd11, 5'd1,  5'd0,  32'h0000_0001);
    send_instr(OP_ANDI,  5'd12, 5'd31, 5'd0,  32'h0);
    send_instr(OP_XORI,  5'd13, 5'd0,  5'd0,  32'h8000_0000);
    send_instr(OP_ORI,   5'd14, 5'd1,  5'd0,  32'h7fff_ffff);
    send_instr(OP_SWAP,  5'd31, 5'd0,  5'd0,  32'h0);
    send_instr(OP_SWAP,  5'd5,  5'd5,  5'd0,  32'h0);
    send_instr(OP_NOP,   5'd31, 5'd0,  5'd0,  32'hffff_ffff);
    send_instr(OP_READ0, 5'd0,  5'd0,  5'd0,  32'h0);
    send_instr(OP_LOAD0, 5'd0,  5'd0,  5'd0,  32'h0);
    send_instr(OP_ADD,   5'd31, 5'd31, 5'd31, 32'hffff_ffff);
    drain_results();

    for (int n = 0; n < ITEM_COUNT; n++) begin
      op = ($urandom_range(0, 49) == 0) ? OP_NOP : OP_W'($urandom_range(0, 14));
      case ($urandom_range(0, 7))
        0:       imm = 32'h0;
        1:       imm = 32'h7fff_ffff;
        2:       imm = 32'h8000_0000;
        3:       imm = 32'hffff_ffff;
        4:       imm = DATA_W'($urandom_range(0, 15));
        default: imm = $urandom;
      endcase
      send_instr(op, draw_idx(), draw_idx(), draw_idx(), imm);
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain_results();
    end
    drain_results();
    repeat (4) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("register_alu_execute_with_flags_core: match");
    end else begin
      $display("register_alu_execute_with_flags_core: mismatch");
    end
    $finish;
  end

endmodule
